[src/uer_pkg.sv]
package uer_pkg;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_TLOW  = 3'd1,
        PH_THIGH = 3'd2,
        PH_CHECK = 3'd3,
        PH_RISE  = 3'd4,
        PH_MEAS  = 3'd5
    } t_phase;

    // per-tick flags handed from the sequencer to the distance stages
    typedef struct packed {
        logic trig;
        logic blink;
        logic done;
        logic good;
    } t_ctrl_res;

    localparam int TICKS_W = 24;
    localparam int WIDTH_W = 15;
    localparam int DIST_W  = 13;

    localparam logic [DIST_W-1:0] DIST_MAX_MM = 13'd4500;

    // width*100/583 == (width*RECIP_K) >> RECIP_SHIFT for every 15-bit width
    localparam int              RECIP_SHIFT = 25;
    localparam int              RECIP_W     = 23;
    localparam logic [RECIP_W-1:0] RECIP_K  = 23'd5755478;
    localparam int              PROD_W      = WIDTH_W + RECIP_W;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_TRIG_LOW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIG_HIGH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RISE_TMO   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ECHO   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE       = 3'd5;

endpackage

[src/uer_ctrl.sv]
module uer_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_echo,
    input  logic [7:0]                    i_trig_low,
    input  logic [7:0]                    i_trig_high,
    input  logic [19:0]                   i_rise_tmo,
    input  logic [uer_pkg::WIDTH_W-1:0]   i_max_echo,
    input  logic [uer_pkg::TICKS_W-1:0]   i_idle,
    output uer_pkg::t_ctrl_res            o_res,
    output logic [uer_pkg::WIDTH_W-1:0]   o_width
);

    uer_pkg::t_phase                 r_phase, n_phase;
    logic [uer_pkg::TICKS_W-1:0]     r_ticks, n_ticks;
    logic [uer_pkg::WIDTH_W-1:0]     r_width, n_width;
    logic                            r_blink_state, n_blink_state;
    logic                            r_blink_lvl, n_blink_lvl;

    logic [uer_pkg::TICKS_W:0]       w_ticks_inc;
    logic                            w_trig;
    logic                            w_done;
    logic                            w_good;

    assign w_ticks_inc = {1'b0, r_ticks} + 25'd1;

    // outputs of the sequencer for this tick
    always_comb begin
        w_trig = 1'b0;
        w_done = 1'b0;
        w_good = 1'b0;
        case (r_phase)
            uer_pkg::PH_THIGH: begin
                w_trig = 1'b1;
            end
            uer_pkg::PH_CHECK: begin
                w_done = i_echo;
            end
            uer_pkg::PH_RISE: begin
                if (i_echo) begin
                    w_done = (i_max_echo == '0);
                end else begin
                    w_done = (w_ticks_inc >= {5'd0, i_rise_tmo});
                end
            end
            uer_pkg::PH_MEAS: begin
                if (i_echo) begin
                    w_done = (r_width >= i_max_echo);
                end else begin
                    w_done = 1'b1;
                    w_good = 1'b1;
                end
            end
            default: begin
                w_trig = 1'b0;
            end
        endcase
    end

    // next state
    always_comb begin
        n_phase       = r_phase;
        n_ticks       = r_ticks;
        n_width       = r_width;
        n_blink_state = r_blink_state;
        n_blink_lvl   = r_blink_lvl;
        case (r_phase)
            uer_pkg::PH_IDLE: begin
                if ({1'b0, r_ticks} < {1'b0, i_idle}) begin
                    n_ticks = w_ticks_inc[uer_pkg::TICKS_W-1:0];
                end else begin
                    n_blink_lvl   = r_blink_state;
                    n_blink_state = ~r_blink_state;
                    // this tick already counts as the first trigger-low tick
                    if (i_trig_low <= 8'd1) begin
                        n_phase = uer_pkg::PH_THIGH;
                        n_ticks = '0;
                    end else begin
                        n_phase = uer_pkg::PH_TLOW;
                        n_ticks = 24'd1;
                    end
                end
            end
            uer_pkg::PH_TLOW: begin
                if (w_ticks_inc >= {17'd0, i_trig_low}) begin
                    n_phase = uer_pkg::PH_THIGH;
                    n_ticks = '0;
                end else begin
                    n_ticks = w_ticks_inc[uer_pkg::TICKS_W-1:0];
                end
            end
            uer_pkg::PH_THIGH: begin
                if (w_ticks_inc >= {17'd0, i_trig_high}) begin
                    n_phase = uer_pkg::PH_CHECK;
                    n_ticks = '0;
                end else begin
                    n_ticks = w_ticks_inc[uer_pkg::TICKS_W-1:0];
                end
            end
            uer_pkg::PH_CHECK: begin
                if (!i_echo) begin
                    n_phase = uer_pkg::PH_RISE;
                    n_ticks = '0;
                end
            end
            uer_pkg::PH_RISE: begin
                if (i_echo) begin
                    n_width = 15'd1;
                    n_phase = uer_pkg::PH_MEAS;
                end else begin
                    n_ticks = w_ticks_inc[uer_pkg::TICKS_W-1:0];
                end
            end
            uer_pkg::PH_MEAS: begin
                if (i_echo) begin
                    n_width = r_width + 15'd1;
                end
            end
            default: begin
                n_phase = uer_pkg::PH_IDLE;
                n_ticks = '0;
            end
        endcase
        if (w_done) begin
            n_phase = uer_pkg::PH_IDLE;
            n_ticks = '0;
            n_width = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= uer_pkg::PH_IDLE;
            r_ticks       <= '0;
            r_width       <= '0;
            r_blink_state <= 1'b0;
            r_blink_lvl   <= 1'b0;
        end else if (i_en) begin
            r_phase       <= n_phase;
            r_ticks       <= n_ticks;
            r_width       <= n_width;
            r_blink_state <= n_blink_state;
            r_blink_lvl   <= n_blink_lvl;
        end
    end

    // result register, width taken before the clear on done
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_res.trig  <= w_trig;
            o_res.blink <= n_blink_lvl;
            o_res.done  <= w_done;
            o_res.good  <= w_good;
            o_width     <= r_width;
        end
    end

endmodule

[src/uer_dist.sv]
module uer_dist (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en_mul,
    input  logic                          i_en_out,
    input  uer_pkg::t_ctrl_res            i_res,
    input  logic [uer_pkg::WIDTH_W-1:0]   i_width,
    input  logic [uer_pkg::DIST_W-1:0]    i_deadband,
    output uer_pkg::t_ctrl_res            o_res,
    output logic [uer_pkg::DIST_W-1:0]    o_dist,
    output logic                          o_report
);

    logic [uer_pkg::PROD_W-1:0]   w_prod;
    uer_pkg::t_ctrl_res           r_res_mul;
    logic [uer_pkg::DIST_W-1:0]   r_quot;
    logic [uer_pkg::DIST_W-1:0]   r_reported, n_reported;

    logic [uer_pkg::DIST_W-1:0]   w_sat;
    logic [uer_pkg::DIST_W-1:0]   w_diff;
    logic                         w_valid;
    logic                         w_rep;

    // width*100/583 as a reciprocal multiply, quotient fits 13 bits
    assign w_prod = uer_pkg::PROD_W'(i_width) * uer_pkg::PROD_W'(uer_pkg::RECIP_K);

    always_ff @(posedge i_clk) begin
        if (i_en_mul) begin
            r_res_mul <= i_res;
            r_quot    <= w_prod[uer_pkg::RECIP_SHIFT +: uer_pkg::DIST_W];
        end
    end

    always_comb begin
        w_valid    = r_res_mul.done & r_res_mul.good;
        w_sat      = (r_quot > uer_pkg::DIST_MAX_MM) ? uer_pkg::DIST_MAX_MM : r_quot;
        w_diff     = (w_sat >= r_reported) ? (w_sat - r_reported) : (r_reported - w_sat);
        w_rep      = w_valid & (w_diff > i_deadband);
        n_reported = w_rep ? w_sat : r_reported;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reported <= '0;
        end else if (i_en_out) begin
            r_reported <= n_reported;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en_out) begin
            o_res    <= r_res_mul;
            o_dist   <= w_valid ? w_sat : '0;
            o_report <= w_rep;
        end
    end

endmodule

[src/ultrasonic_echo_ranger.sv]
// Ultrasonic pulse/echo ranger. Each input transaction is one microsecond tick carrying the
// sampled echo pin in bit 0, and each tick gives exactly one output transaction: trigger and
// blink pin levels, a done flag, an ok flag, the distance in mm (width*100/583, at most 4500)
// and a report flag when the distance moved beyond the deadband. One tick is taken every clock
// while the pipeline advances; a tick's result passes through an input register, the
// sequencer result register, the multiplier register and the output register. The pipeline
// advances whenever the output register is empty or being taken, so it stalls only when the
// output side holds off. Configuration registers are written by index and act at once.
module ultrasonic_echo_ranger (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [7:0]                        i_s_axis_tdata,  // [0] echo_level
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [0] trigger_level, [1] blink_level, [2] done_res, [3] ok, [16:4] distance_mm, [17] report
    output logic [23:0]                       o_m_axis_tdata,
    input  logic                              i_cfg_we,
    input  logic [uer_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [uer_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    logic [7:0]                        r_trig_low;
    logic [7:0]                        r_trig_high;
    logic [19:0]                       r_rise_tmo;
    logic [uer_pkg::WIDTH_W-1:0]       r_max_echo;
    logic [uer_pkg::DIST_W-1:0]        r_deadband;
    logic [uer_pkg::TICKS_W-1:0]       r_idle;

    logic                              w_adv;
    logic                              r_v0, r_v1, r_v2, r_v3;
    logic                              r_echo;

    uer_pkg::t_ctrl_res                w_res_ctrl;
    logic [uer_pkg::WIDTH_W-1:0]       w_width;
    uer_pkg::t_ctrl_res                w_res_out;
    logic [uer_pkg::DIST_W-1:0]        w_dist;
    logic                              w_report;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trig_low  <= 8'd4;
            r_trig_high <= 8'd10;
            r_rise_tmo  <= 20'd600000;
            r_max_echo  <= 15'd26235;
            r_deadband  <= 13'd10;
            r_idle      <= 24'd1000000;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                uer_pkg::CFG_TRIG_LOW:  r_trig_low  <= i_cfg_data[7:0];
                uer_pkg::CFG_TRIG_HIGH: r_trig_high <= i_cfg_data[7:0];
                uer_pkg::CFG_RISE_TMO:  r_rise_tmo  <= i_cfg_data[19:0];
                uer_pkg::CFG_MAX_ECHO:  r_max_echo  <= i_cfg_data[uer_pkg::WIDTH_W-1:0];
                uer_pkg::CFG_DEADBAND:  r_deadband  <= i_cfg_data[uer_pkg::DIST_W-1:0];
                uer_pkg::CFG_IDLE:      r_idle      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // whole pipeline moves together when the output register can take a new transaction
    assign w_adv           = !r_v3 || i_m_axis_tready;
    assign o_s_axis_tready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_adv) begin
            r_v0 <= i_s_axis_tvalid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && i_s_axis_tvalid) begin
            r_echo <= i_s_axis_tdata[0];
        end
    end

    uer_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_adv && r_v0),
        .i_echo      (r_echo),
        .i_trig_low  (r_trig_low),
        .i_trig_high (r_trig_high),
        .i_rise_tmo  (r_rise_tmo),
        .i_max_echo  (r_max_echo),
        .i_idle      (r_idle),
        .o_res       (w_res_ctrl),
        .o_width     (w_width)
    );

    uer_dist u_dist (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en_mul   (w_adv && r_v1),
        .i_en_out   (w_adv && r_v2),
        .i_res      (w_res_ctrl),
        .i_width    (w_width),
        .i_deadband (r_deadband),
        .o_res      (w_res_out),
        .o_dist     (w_dist),
        .o_report   (w_report)
    );

    assign o_m_axis_tvalid = r_v3;
    assign o_m_axis_tdata  = {6'd0, w_report, w_dist, w_res_out.good, w_res_out.done,
                              w_res_out.blink, w_res_out.trig};

    // distance never exceeds the saturation limit
    a_dist_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[16:4] <= uer_pkg::DIST_MAX_MM))
        else $error("distance above saturation limit");

    // a failed or absent measurement carries no distance and no report
    a_fail_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tdata[3]) |->
        (o_m_axis_tdata[16:4] == '0 && !o_m_axis_tdata[17]))
        else $error("distance or report without a valid measurement");

    // ok only with done, and a measurement never ends while the trigger is high
    a_done_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ((!o_m_axis_tdata[3] || o_m_axis_tdata[2]) &&
                             !(o_m_axis_tdata[2] && o_m_axis_tdata[0])))
        else $error("inconsistent done, ok and trigger flags");

endmodule

[tb/sv/ultrasonic_echo_ranger_test.sv]
`timescale 1ns / 1ps

module ultrasonic_echo_ranger_test;

    localparam int CYCLE_LIMIT       = 200_000;
    localparam int ECHO_US_PER_100MM = 583;
    localparam int MAX_SHOWN         = 10;

    // same bit order as the master tdata, report in the top bit
    typedef struct packed {
        logic                       report;
        logic [uer_pkg::DIST_W-1:0] dist_mm;
        logic                       ok;
        logic                       done;
        logic                       blink;
        logic                       trig;
    } t_ranger_out;

    logic                           clk        = 1'b0;
    logic                           rst_n      = 1'b0;
    logic                           src_valid  = 1'b0;
    logic                           src_echo   = 1'b0;
    logic                           sink_ready = 1'b0;
    logic                           cfg_we     = 1'b0;
    logic [uer_pkg::CFG_IDX_W-1:0]  cfg_idx    = '0;
    logic [uer_pkg::CFG_DATA_W-1:0] cfg_data   = '0;
    wire                            s_ready;
    wire                            m_valid;
    wire  [23:0]                    m_data;

    ultrasonic_echo_ranger i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (src_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  ({7'd0, src_echo}),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (sink_ready),
        .o_m_axis_tdata  (m_data),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    // register copies
    int unsigned cfg_low      = 4;
    int unsigned cfg_high     = 10;
    int unsigned cfg_tmo      = 600000;
    int unsigned cfg_max      = 26235;
    int unsigned cfg_deadband = 10;
    int unsigned cfg_idle     = 1000000;

    // ranger state
    uer_pkg::t_phase rg_phase    = uer_pkg::PH_IDLE;
    int unsigned     rg_ticks    = 0;
    int unsigned     rg_width    = 0;
    logic            blink_next  = 1'b0;
    logic            blink_lvl   = 1'b0;
    int unsigned     reported_mm = 0;

    bit          echo_ticks_q[$];
    t_ranger_out tick_results_q[$];

    bit          gaps_on     = 1'b0;
    int          src_gap     = 0;
    int          sink_gap    = 0;
    logic        res_seen    = 1'b0;
    logic [23:0] res_data    = '0;
    int          n_cycles    = 0;
    int          n_queued    = 0;
    int          n_ticks     = 0;
    int          n_results   = 0;
    int          n_mismatch  = 0;
    int          n_done      = 0;
    int          n_ok        = 0;
    int          n_reports   = 0;
    int          n_writes    = 0;

    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles == CYCLE_LIMIT) begin
            $display("no end after %0d cycles, %0d results pending", n_cycles,
                     tick_results_q.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // one echo tick through the ranger, queues the result it should give
    task automatic predict_tick(input logic echo);
        t_ranger_out res;
        logic        trig;
        logic        done;
        logic        good;
        int unsigned mm;
        int unsigned diff;
        res  = '0;
        trig = 1'b0;
        done = 1'b0;
        good = 1'b0;
        case (rg_phase)
            uer_pkg::PH_IDLE: begin
                if (rg_ticks < cfg_idle) begin
                    rg_ticks++;
                end else begin
                    blink_lvl  = blink_next;
                    blink_next = ~blink_next;
                    rg_ticks   = 1;
                    if (rg_ticks >= cfg_low) begin
                        rg_phase = uer_pkg::PH_THIGH;
                        rg_ticks = 0;
                    end else begin
                        rg_phase = uer_pkg::PH_TLOW;
                    end
                end
            end
            uer_pkg::PH_TLOW: begin
                rg_ticks++;
                if (rg_ticks >= cfg_low) begin
                    rg_phase = uer_pkg::PH_THIGH;
                    rg_ticks = 0;
                end
            end
            uer_pkg::PH_THIGH: begin
                trig = 1'b1;
                rg_ticks++;
                if (rg_ticks >= cfg_high) begin
                    rg_phase = uer_pkg::PH_CHECK;
                    rg_ticks = 0;
                end
            end
            uer_pkg::PH_CHECK: begin
                if (echo) begin
                    done = 1'b1;
                end else begin
                    rg_phase = uer_pkg::PH_RISE;
                    rg_ticks = 0;
                end
            end
            uer_pkg::PH_RISE: begin
                if (echo) begin
                    if (cfg_max == 0) begin
                        done = 1'b1;
                    end else begin
                        rg_width = 1;
                        rg_phase = uer_pkg::PH_MEAS;
                    end
                end else begin
                    rg_ticks++;
                    if (rg_ticks >= cfg_tmo) done = 1'b1;
                end
            end
            uer_pkg::PH_MEAS: begin
                if (echo) begin
                    if (rg_width >= cfg_max) done = 1'b1;
                    else rg_width++;
                end else begin
                    done = 1'b1;
                    good = 1'b1;
                end
            end
            default: begin
                rg_phase = uer_pkg::PH_IDLE;
                rg_ticks = 0;
            end
        endcase
        if (done) begin
            n_done++;
            if (good) begin
                n_ok++;
                mm = rg_width * 100 / ECHO_US_PER_100MM;
                if (mm > uer_pkg::DIST_MAX_MM) mm = uer_pkg::DIST_MAX_MM;
                diff = (mm >= reported_mm) ? mm - reported_mm : reported_mm - mm;
                if (diff > cfg_deadband) begin
                    res.report  = 1'b1;
                    reported_mm = mm;
                    n_reports++;
                end
                res.dist_mm = mm[uer_pkg::DIST_W-1:0];
            end
            res.done = 1'b1;
            res.ok   = good;
            rg_phase = uer_pkg::PH_IDLE;
            rg_ticks = 0;
            rg_width = 0;
        end
        res.trig  = trig;
        res.blink = blink_lvl;
        tick_results_q.push_back(res);
    endtask

    task automatic check_result(input logic [23:0] data);
        t_ranger_out got;
        t_ranger_out want;
        got = t_ranger_out'(data[17:0]);
        n_results++;
        if (tick_results_q.size() == 0) begin
            n_mismatch++;
            if (n_mismatch <= MAX_SHOWN)
                $display("result %0d: %h arrived with no tick pending", n_results, data);
            return;
        end
        want = tick_results_q.pop_front();
        if (got.trig !== want.trig || got.blink !== want.blink || got.done !== want.done ||
            got.ok !== want.ok || got.dist_mm !== want.dist_mm ||
            got.report !== want.report || data[23:18] !== 6'd0) begin
            n_mismatch++;
            if (n_mismatch <= MAX_SHOWN)
                $display({"result %0d: want trig %b blink %b done %b ok %b mm %0d rep %b,",
                          " got trig %b blink %b done %b ok %b mm %0d rep %b pad %h"},
                         n_results, want.trig, want.blink, want.done, want.ok,
                         want.dist_mm, want.report, got.trig, got.blink, got.done,
                         got.ok, got.dist_mm, got.report, data[23:18]);
        end
    endtask

    // tick driver
    always @(posedge clk) begin
        if (!rst_n) begin
            src_valid <= 1'b0;
            src_gap   <= 0;
        end else begin
            if (src_valid && s_ready) begin
                predict_tick(src_echo);
                n_ticks++;
            end
            if (!src_valid || s_ready) begin
                if (src_gap != 0) begin
                    src_gap   <= src_gap - 1;
                    src_valid <= 1'b0;
                end else if (gaps_on && $urandom_range(0, 11) == 0) begin
                    src_gap   <= $urandom_range(0, 5);
                    src_valid <= 1'b0;
                end else if (echo_ticks_q.size() != 0) begin
                    src_echo  <= echo_ticks_q.pop_front();
                    src_valid <= 1'b1;
                end else begin
                    src_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor, compared on the falling edge so the tick predictions are settled
    always @(posedge clk) begin
        if (!rst_n) begin
            sink_ready <= 1'b0;
            sink_gap   <= 0;
            res_seen   <= 1'b0;
        end else begin
            res_seen <= m_valid && sink_ready;
            res_data <= m_data;
            if (sink_gap != 0) begin
                sink_gap   <= sink_gap - 1;
                sink_ready <= 1'b0;
            end else if (gaps_on && $urandom_range(0, 9) == 0) begin
                sink_gap   <= $urandom_range(0, 5);
                sink_ready <= 1'b0;
            end else begin
                sink_ready <= 1'b1;
            end
        end
    end

    always @(negedge clk) begin
        if (res_seen) check_result(res_data);
    end

    task automatic push_level(input bit lvl, input int unsigned n);
        repeat (n) begin
            echo_ticks_q.push_back(lvl);
            n_queued++;
        end
    endtask

    task automatic push_noise(input int unsigned n);
        repeat (n) begin
            echo_ticks_q.push_back(1'($urandom_range(0, 1)));
            n_queued++;
        end
    endtask

    task automatic wait_ticks_taken();
        while (echo_ticks_q.size() != 0 || src_valid) @(negedge clk);
    endtask

    task automatic wait_ranger_idle();
        wait_ticks_taken();
        while (tick_results_q.size() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input logic [uer_pkg::CFG_IDX_W-1:0] idx,
                             input int unsigned value);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value[uer_pkg::CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            uer_pkg::CFG_TRIG_LOW:  cfg_low      = value & 32'hFF;
            uer_pkg::CFG_TRIG_HIGH: cfg_high     = value & 32'hFF;
            uer_pkg::CFG_RISE_TMO:  cfg_tmo      = value & 32'hFFFFF;
            uer_pkg::CFG_MAX_ECHO:  cfg_max      = value & 32'h7FFF;
            uer_pkg::CFG_DEADBAND:  cfg_deadband = value & 32'h1FFF;
            uer_pkg::CFG_IDLE:      cfg_idle     = value & 32'hFFFFFF;
            default: ;
        endcase
        n_writes++;
        @(negedge clk);
    endtask

    // feeds ticks until the ranger sits in the given phase; echo is don't-care
    // until the check
    task automatic advance_to(input uer_pkg::t_phase target);
        int unsigned n;
        wait_ticks_taken();
        while (rg_phase != target) begin
            case (rg_phase)
                uer_pkg::PH_IDLE: begin
                    n = (rg_ticks < cfg_idle) ? cfg_idle - rg_ticks + 1 : 1;
                    push_noise(n);
                end
                uer_pkg::PH_TLOW: begin
                    n = (cfg_low > rg_ticks) ? cfg_low - rg_ticks : 1;
                    push_noise(n);
                end
                uer_pkg::PH_THIGH: begin
                    n = (cfg_high > rg_ticks) ? cfg_high - rg_ticks : 1;
                    push_noise(n);
                end
                uer_pkg::PH_CHECK: push_level(1'b0, 1);
                uer_pkg::PH_RISE:  push_level(1'b1, 1);
                default:           push_level(1'b0, 1);
            endcase
            wait_ticks_taken();
        end
    endtask

    task automatic random_measurement();
        int unsigned kind;
        int unsigned cap;
        int unsigned lim;
        kind = $urandom_range(0, 99);
        if (kind < 70) begin
            advance_to(uer_pkg::PH_RISE);
            lim = (cfg_tmo - 1 < 12) ? cfg_tmo - 1 : 12;
            push_level(1'b0, $urandom_range(0, lim));
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6: cap = 20;
                7, 8:                cap = 150;
                default:             cap = cfg_max;
            endcase
            if (cap > cfg_max) cap = cfg_max;
            push_level(1'b1, $urandom_range(1, cap));
            push_level(1'b0, 1);
        end else if (kind < 78) begin
            advance_to(uer_pkg::PH_CHECK);
            push_level(1'b1, 1);
        end else if (kind < 86) begin
            advance_to(uer_pkg::PH_RISE);
            push_level(1'b0, cfg_tmo);
        end else if (kind < 93) begin
            advance_to(uer_pkg::PH_RISE);
            push_level(1'b1, cfg_max + $urandom_range(1, 3));
        end else begin
            push_noise($urandom_range(1, 20));
        end
    endtask

    initial begin
        int p;
        int first;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        gaps_on = 1'b1;

        // idle count under reset settings, then under the longest idle
        push_noise(4);
        wait_ranger_idle();
        write_reg(uer_pkg::CFG_IDLE, 24'hFFFFFF);
        push_noise(4);
        wait_ranger_idle();
        // idle dropped below the elapsed count: next tick starts a measurement
        write_reg(uer_pkg::CFG_IDLE, 0);
        write_reg(uer_pkg::CFG_TRIG_LOW, 0);
        write_reg(uer_pkg::CFG_TRIG_HIGH, 0);
        write_reg(uer_pkg::CFG_RISE_TMO, 0);
        write_reg(uer_pkg::CFG_DEADBAND, 0);
        advance_to(uer_pkg::PH_CHECK);
        push_level(1'b1, 1);            // echo already high at the check
        advance_to(uer_pkg::PH_RISE);
        push_level(1'b0, 1);            // zero rise timeout
        wait_ranger_idle();
        write_reg(uer_pkg::CFG_MAX_ECHO, 0);
        write_reg(uer_pkg::CFG_RISE_TMO, 5);
        advance_to(uer_pkg::PH_RISE);
        push_level(1'b1, 1);            // zero max width fails at the rise
        wait_ranger_idle();
        write_reg(uer_pkg::CFG_MAX_ECHO, 3);
        write_reg(uer_pkg::CFG_TRIG_LOW, 1);
        write_reg(uer_pkg::CFG_TRIG_HIGH, 2);
        advance_to(uer_pkg::PH_RISE);
        push_level(1'b0, 1);
        push_level(1'b1, 4);            // pulse one tick too long
        advance_to(uer_pkg::PH_RISE);
        push_level(1'b1, 2);
        push_level(1'b0, 1);
        advance_to(uer_pkg::PH_RISE);
        push_level(1'b0, 5);            // rise timeout
        wait_ranger_idle();
        write_reg(uer_pkg::CFG_RISE_TMO, 20'hFFFFF);
        advance_to(uer_pkg::PH_RISE);
        push_level(1'b0, 30);
        wait_ranger_idle();
        // timeout lowered under the elapsed wait mid-measurement
        write_reg(uer_pkg::CFG_RISE_TMO, 20);
        push_level(1'b0, 1);

        for (p = 0; p < 7; p++) begin
            wait_ranger_idle();
            gaps_on = (p != 6);
            write_reg(uer_pkg::CFG_TRIG_LOW, (p == 0) ? 255 : $urandom_range(1, 8));
            write_reg(uer_pkg::CFG_TRIG_HIGH, (p == 0) ? 255 : $urandom_range(1, 12));
            write_reg(uer_pkg::CFG_RISE_TMO, $urandom_range(1, 40));
            write_reg(uer_pkg::CFG_MAX_ECHO, (p % 3 == 1) ? $urandom_range(1, 20)
                                                          : $urandom_range(60, 400));
            write_reg(uer_pkg::CFG_DEADBAND, (p == 0) ? 4500 : $urandom_range(0, 8));
            write_reg(uer_pkg::CFG_IDLE, $urandom_range(0, 20));
            first = n_queued;
            while (n_queued - first < 100) begin
                random_measurement();
            end
        end

        wait_ticks_taken();
        while (tick_results_q.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        $display("%0d echo ticks over %0d register writes: %0d measurements ended, %0d valid",
                 n_ticks, n_writes, n_done, n_ok);
        $display("%0d distance reports, %0d results checked, %0d mismatches",
                 n_reports, n_results, n_mismatch);
        if (n_mismatch == 0 && tick_results_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[files.f]
src/uer_pkg.sv
src/uer_ctrl.sv
src/uer_dist.sv
src/ultrasonic_echo_ranger.sv
tb/sv/ultrasonic_echo_ranger_test.sv
